// ===== rtl/psdm_pkg.sv =====
// ----------------------------------------------------------------------------
// psdm_pkg
// Shared types and constants for the pairwise squared distance matrix unit.
// ----------------------------------------------------------------------------
package psdm_pkg;

   // fixed field widths of the channels
   localparam int NUM_COORDS = 8;
   localparam int COORD_W    = 16;
   localparam int INDEX_W    = 4;
   localparam int DIST_W     = 35;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIMS_IN_USE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINGLE_DIM_MODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELECTED_DIM    = 2'd2;

   // result status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   typedef struct packed {
      logic                       restart;
      logic signed [COORD_W-1:0]  coord_0;
      logic signed [COORD_W-1:0]  coord_1;
      logic signed [COORD_W-1:0]  coord_2;
      logic signed [COORD_W-1:0]  coord_3;
      logic signed [COORD_W-1:0]  coord_4;
      logic signed [COORD_W-1:0]  coord_5;
      logic signed [COORD_W-1:0]  coord_6;
      logic signed [COORD_W-1:0]  coord_7;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0] row_index;
      logic [INDEX_W-1:0] col_index;
      logic [DIST_W-1:0]  distance;
      logic               last;
      logic               status;
   } rsp_payload_type;

   // one result slot travelling down the pipeline beside the data
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic               last;
      logic               status;
      logic               zero;
   } token_type;

endpackage

// ===== rtl/pairwise_squared_distance_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// pairwise_squared_distance_matrix_unit
// Builds a squared Euclidean distance matrix one point at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one point per transfer (restart flag and up to 8 coordinates).
//            The point is stored as row i of the set; restart makes it row 0.
//   rsp_*  : i+1 results per point: distances to rows 0..i-1 in order, then
//            the zero diagonal entry (i, i) with last set. With the store
//            full the point is dropped and one result with status set comes.
//   csr_*  : register writes, always ready; write only with no point in flight.
// Timing:
//   Each result passes the row sequencer and the store read, lane, merge and
//   output registers. Results follow one per cycle while rsp_stall is low; the
//   sequencer issues one stored row per cycle unless stalled and takes the next
//   point only once the final result of the current one reaches the output
//   register.
//   The next point is taken while the final result still waits on rsp_stall.
// Reset: synchronous; empties the set and loads the register defaults.
//   Store rows need no clearing; only written rows are read.
// Stall: rsp_stall freezes the whole pipeline, store read port included.
// ----------------------------------------------------------------------------
module pairwise_squared_distance_matrix_unit #(
   parameter int MAX_POINTS = 16,
   parameter int MAX_DIMS   = 8,
   parameter int COORD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  psdm_pkg::req_payload_type             req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output psdm_pkg::rsp_payload_type             rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psdm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [psdm_pkg::CSR_DATA_W-1:0]       csr_data
);

   import psdm_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int ROW_W = MAX_DIMS * COORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } seq_state_type;

   // configuration
   logic [3:0] dims_ff, dims_in;
   logic       single_ff, single_in;
   logic [2:0] sel_ff, sel_in;

   // sequencer
   seq_state_type  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic             drop_ff, drop_in;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] cur_ff;

   // pipeline
   token_type        tok_issue;
   token_type        t1_ff, t2_ff, t3_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_payload_ff;

   logic                                accept;
   logic                                advance;
   logic                                full;
   logic                                more_pairs;
   logic [CNT_W-1:0]                    eff_cnt;
   logic [NUM_COORDS-1:0][COORD_W-1:0]  coord_raw;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] new_row;
   logic [ROW_W-1:0]                    rd_row;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] old_row;
   logic [MAX_DIMS-1:0]                 lane_en;
   logic [MAX_DIMS-1:0][DIST_W-1:0]     lane_sq;
   logic [DIST_W-1:0]                   merge_sum;
   logic [3:0]                          sel_eff;
   logic [3:0]                          dims_hi;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // register writes
   always_comb begin
      dims_in   = dims_ff;
      single_in = single_ff;
      sel_in    = sel_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DIMS_IN_USE:     dims_in   = csr_data[3:0];
            CSR_SINGLE_DIM_MODE: single_in = csr_data[0];
            CSR_SELECTED_DIM:    sel_in    = csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= 4'd8;
         single_ff <= 1'b0;
         sel_ff    <= 3'd0;
      end else begin
         dims_ff   <= dims_in;
         single_ff <= single_in;
         sel_ff    <= sel_in;
      end
   end

   // lane enables from the dimension settings, clamped to the lane count
   always_comb begin
      sel_eff = ({1'b0, sel_ff} >= 4'(MAX_DIMS)) ? 4'(MAX_DIMS - 1) : {1'b0, sel_ff};
      if (dims_ff == 4'd0) begin
         dims_hi = 4'd1;
      end else if (dims_ff > 4'(MAX_DIMS)) begin
         dims_hi = 4'(MAX_DIMS);
      end else begin
         dims_hi = dims_ff;
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         lane_en[d] = single_ff ? (sel_eff == 4'(d)) : (4'(d) < dims_hi);
      end
   end

   // incoming coordinates: low COORD_BITS of the zero-extended field
   always_comb begin
      logic [COORD_BITS+COORD_W-1:0] wide;
      coord_raw[0] = req_payload.coord_0;
      coord_raw[1] = req_payload.coord_1;
      coord_raw[2] = req_payload.coord_2;
      coord_raw[3] = req_payload.coord_3;
      coord_raw[4] = req_payload.coord_4;
      coord_raw[5] = req_payload.coord_5;
      coord_raw[6] = req_payload.coord_6;
      coord_raw[7] = req_payload.coord_7;
      wide = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         wide       = {COORD_BITS'(0), coord_raw[d]};
         new_row[d] = wide[COORD_BITS-1:0];
      end
   end

   // row sequencer
   always_comb begin
      accept     = req_valid && (state_ff == ST_IDLE);
      advance    = !rsp_valid_ff || !rsp_stall;
      eff_cnt    = req_payload.restart ? '0 : cnt_ff;
      full       = (eff_cnt >= CNT_W'(MAX_POINTS));
      more_pairs = !drop_ff && (j_ff < i_ff);

      tok_issue.valid  = (state_ff == ST_RUN);
      tok_issue.row    = drop_ff ? '0 : INDEX_W'(i_ff);
      tok_issue.col    = drop_ff ? '0 : (more_pairs ? INDEX_W'(j_ff) : INDEX_W'(i_ff));
      tok_issue.last   = !more_pairs;
      tok_issue.status = drop_ff ? STATUS_DROPPED : STATUS_OK;
      tok_issue.zero   = !more_pairs;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      drop_in  = drop_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               j_in     = '0;
               drop_in  = full;
               if (!full) begin
                  i_in   = eff_cnt[IDX_W-1:0];
                  cnt_in = eff_cnt + CNT_W'(1);
               end
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (more_pairs) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // free once the final result moves into the output register
            if (advance && t3_ff.valid && t3_ff.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   // current point, compared against every stored row
   always_ff @(posedge clock) begin
      if (accept && !full) begin
         cur_ff <= new_row;
      end
   end

   psdm_store #(
      .DEPTH  (MAX_POINTS),
      .WIDTH  (ROW_W),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (accept && !full),
      .wr_addr    (eff_cnt[IDX_W-1:0]),
      .wr_data    (new_row),
      .rd_en      (advance),
      .rd_addr    (j_ff),
      .rd_data_ff (rd_row)
   );

   assign old_row = rd_row;

   // one lane per coordinate
   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
      psdm_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock   (clock),
         .advance (advance),
         .enable  (lane_en[d]),
         .coord_a (cur_ff[d]),
         .coord_b (old_row[d]),
         .sq_ff   (lane_sq[d])
      );
   end

   psdm_merge #(
      .LANES (MAX_DIMS)
   ) u_merge (
      .clock   (clock),
      .advance (advance),
      .sq      (lane_sq),
      .sum     (merge_sum)
   );

   // result tags alongside store read, lanes and merge
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
      end else if (advance) begin
         t1_ff <= tok_issue;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= t3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff.row_index <= t3_ff.row;
         rsp_payload_ff.col_index <= t3_ff.col;
         rsp_payload_ff.distance  <= t3_ff.zero ? '0 : merge_sum;
         rsp_payload_ff.last      <= t3_ff.last;
         rsp_payload_ff.status    <= t3_ff.status;
      end
   end

endmodule

// ===== rtl/psdm_store.sv =====
// ----------------------------------------------------------------------------
// psdm_store
// Point store: one row per point, one write port, one registered read port.
// ----------------------------------------------------------------------------
module psdm_store #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 128,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, held while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/psdm_lane.sv =====
// ----------------------------------------------------------------------------
// psdm_lane
// One coordinate lane: squared difference of two coordinates, registered.
// ----------------------------------------------------------------------------
module psdm_lane #(
   parameter int COORD_BITS = 16
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic                        enable,
   input  logic [COORD_BITS-1:0]       coord_a,
   input  logic [COORD_BITS-1:0]       coord_b,
   output logic [psdm_pkg::DIST_W-1:0] sq_ff
);

   import psdm_pkg::*;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;

   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] mag;
   logic [SQ_W-1:0]   prod;
   logic [DIST_W-1:0] sq_in;

   // sign-extended difference, magnitude, square; result kept modulo 2^DIST_W
   always_comb begin
      diff  = {coord_a[COORD_BITS-1], coord_a} - {coord_b[COORD_BITS-1], coord_b};
      mag   = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      prod  = SQ_W'(mag) * SQ_W'(mag);
      sq_in = enable ? DIST_W'(prod) : '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff <= sq_in;
      end
   end

endmodule

// ===== rtl/psdm_merge.sv =====
// ----------------------------------------------------------------------------
// psdm_merge
// Merge stage: registered pairwise sums of the lane squares, then final sum.
// ----------------------------------------------------------------------------
module psdm_merge #(
   parameter int LANES = 8
) (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic [LANES-1:0][psdm_pkg::DIST_W-1:0] sq,
   output logic [psdm_pkg::DIST_W-1:0]            sum
);

   import psdm_pkg::*;

   localparam int HALF = (LANES + 1) / 2;

   logic [2*HALF-1:0][DIST_W-1:0] padded;
   logic [HALF-1:0][DIST_W-1:0]   pair_in;
   logic [HALF-1:0][DIST_W-1:0]   pair_ff;

   // first level: sums of neighboring lanes
   always_comb begin
      padded = '0;
      for (int k = 0; k < LANES; k++) begin
         padded[k] = sq[k];
      end
      for (int k = 0; k < HALF; k++) begin
         pair_in[k] = padded[2*k] + padded[2*k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in;
      end
   end

   // second level: one term per lane pair, wraps modulo 2^DIST_W
   always_comb begin
      sum = '0;
      for (int k = 0; k < HALF; k++) begin
         sum = sum + pair_ff[k];
      end
   end

endmodule

// ===== test/tb_pairwise_squared_distance_matrix_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pairwise_squared_distance_matrix_unit
// Self-checking bench for the pairwise squared distance matrix unit. A table
// of directed points covers coordinate extremes, a full store and restarts.
// Random point sets then run under several register settings, with random
// stalls on both channels. A local model of the point store predicts every
// matrix entry, and each entry is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_pairwise_squared_distance_matrix_unit;
   import psdm_pkg::*;

   localparam int CLOCK_HALF  = 5;
   localparam int MAX_ROWS    = 16;
   localparam int LONG_HOLD   = 200;
   localparam int TAIL_CYCLES = 24;
   localparam int RUN_LIMIT   = 10_000_000;

   // index with no register behind it; writes to it are ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
   localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;

   localparam rsp_payload_type ROW0_DIAG = '{4'd0, 4'd0, 35'd0, 1'b1, STATUS_OK};
   localparam rsp_payload_type DROPPED   = '{4'd0, 4'd0, 35'd0, 1'b1, STATUS_DROPPED};
   localparam rsp_payload_type NOT_TYPED = '0;

   // one directed point; a typed result replaces the predicted one
   typedef struct packed {
      req_payload_type point;
      logic            check_typed;
      rsp_payload_type typed_result;
   } point_row_type;

   localparam int DIRECTED_ROWS = 21;
   localparam point_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{'{1'b1, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 1'b1, ROW0_DIAG},
      '{'{1'b0, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        1'b0, NOT_TYPED},
      '{'{1'b0, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
        1'b0, NOT_TYPED},
      '{'{1'b0, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX}, 1'b0, NOT_TYPED},
      '{'{1'b0, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8},
        1'b0, NOT_TYPED},
      '{'{1'b0, -16'sd8, -16'sd7, -16'sd6, -16'sd5, -16'sd4, -16'sd3, -16'sd2, -16'sd1},
        1'b0, NOT_TYPED},
      '{'{1'b0, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555,
          16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA,
          16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'sh0F0F, 16'shF0F0, 16'sh0F0F, 16'shF0F0,
          16'sh0F0F, 16'shF0F0, 16'sh0F0F, 16'shF0F0}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'sh00FF, 16'shFF00, 16'sh00FF, 16'shFF00,
          16'sh00FF, 16'shFF00, 16'sh00FF, 16'shFF00}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'sd1000, -16'sd1000, 16'sd2000, -16'sd2000,
          16'sd4000, -16'sd4000, 16'sd8000, -16'sd8000}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'sd12345, -16'sd23456, 16'sd31000, -16'sd31000,
          16'sd7, -16'sd7, 16'sd16384, -16'sd16384}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'sh7FFE, 16'sh8001, 16'sh7FFE, 16'sh8001,
          16'sh8001, 16'sh7FFE, 16'sh8001, 16'sh7FFE}, 1'b0, NOT_TYPED},
      '{'{1'b0, 16'sd256, -16'sd256, 16'sd0, 16'sd0, C_MAX, C_MIN, 16'sd3, -16'sd3},
        1'b0, NOT_TYPED},
      // store holds sixteen rows now: the next two points are dropped
      '{'{1'b0, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5},
        1'b1, DROPPED},
      '{'{1'b0, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b1, DROPPED},
      // restart on a full store starts over at row zero
      '{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        1'b1, ROW0_DIAG},
      '{'{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, C_MAX},
        1'b0, NOT_TYPED},
      '{'{1'b1, C_MIN, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        1'b1, ROW0_DIAG}
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_payload_type            req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_payload_type            rsp_payload;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   // local copy of the point set and the registers
   logic signed [COORD_W-1:0]  point_rows [MAX_ROWS][NUM_COORDS];
   int unsigned                rows_held;
   logic [3:0]                 dims_reg;
   logic                       mode_reg;
   logic [2:0]                 sel_reg;
   rsp_payload_type            matrix_entries_due [$];

   // random point set shaping
   int unsigned                set_len;
   int unsigned                set_target;

   bit                         req_idle_on = 1'b0;
   bit                         rsp_idle_on = 1'b0;
   bit                         hold_asked  = 1'b0;

   int                         fail_count      = 0;
   int                         results_checked = 0;
   int                         points_sent     = 0;
   int                         points_dropped  = 0;
   int                         settings_used   = 0;

   always #CLOCK_HALF clock = ~clock;

   pairwise_squared_distance_matrix_unit #(
      .MAX_POINTS (MAX_ROWS),
      .MAX_DIMS   (NUM_COORDS),
      .COORD_BITS (COORD_W)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] %s", $realtime, msg);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      if ($urandom_range(19) == 0)
         return $urandom_range(40, 10);
      if ($urandom_range(1) == 0)
         return 0;
      return $urandom_range(3, 1);
   endfunction

   // add one expected entry behind the ones already due
   function automatic void append_due(input rsp_payload_type e);
      matrix_entries_due = {matrix_entries_due, e};
   endfunction

   // Store one accepted point and queue the matrix row it produces.
   function automatic void compute_distance_row(input req_payload_type p,
                                                input bit use_typed,
                                                input rsp_payload_type typed_result);
      logic signed [COORD_W-1:0] c [NUM_COORDS];
      rsp_payload_type           r;
      int unsigned               row;
      int unsigned               lo;
      int unsigned               hi;
      longint                    diff;
      logic [63:0]               acc;
      c = '{p.coord_0, p.coord_1, p.coord_2, p.coord_3,
            p.coord_4, p.coord_5, p.coord_6, p.coord_7};
      if (p.restart)
         rows_held = 0;
      if (rows_held >= MAX_ROWS) begin
         // store full: point dropped, single flagged entry
         points_dropped++;
         if (!use_typed)
            append_due(DROPPED);
      end else begin
         row = rows_held;
         for (int d = 0; d < NUM_COORDS; d++)
            point_rows[row][d] = c[d];
         rows_held = row + 1;
         if (mode_reg) begin
            lo = sel_reg;
            hi = lo + 1;
         end else begin
            lo = 0;
            hi = (dims_reg == 0) ? 1 : (dims_reg > NUM_COORDS) ? NUM_COORDS : dims_reg;
         end
         for (int unsigned j = 0; j < row; j++) begin
            acc = '0;
            for (int unsigned d = lo; d < hi; d++) begin
               diff = longint'(point_rows[row][d]) - longint'(point_rows[j][d]);
               acc += diff * diff;
            end
            r = '{INDEX_W'(row), INDEX_W'(j), acc[DIST_W-1:0], 1'b0, STATUS_OK};
            if (!use_typed)
               append_due(r);
         end
         // diagonal closes the row
         r = '{INDEX_W'(row), INDEX_W'(row), '0, 1'b1, STATUS_OK};
         if (!use_typed)
            append_due(r);
      end
      if (use_typed)
         append_due(typed_result);
   endfunction

   // Offer one point, hold it until the transfer, then maybe idle.
   task automatic offer_point(input req_payload_type p, input bit use_typed,
                              input rsp_payload_type typed_result);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      compute_distance_row(p, use_typed, typed_result);
      points_sent++;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (matrix_entries_due.size() != 0)
         @(posedge clock);
   endtask

   // Register writes back to back; valid drops once after the last one.
   task automatic configure(input logic [CSR_DATA_W-1:0] dims,
                            input logic [CSR_DATA_W-1:0] mode_bits,
                            input logic [CSR_DATA_W-1:0] sel_bits,
                            input bit poke_unused);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  val [4];
      int                     n;
      idx = '{CSR_DIMS_IN_USE, CSR_SINGLE_DIM_MODE, CSR_SELECTED_DIM, CSR_UNUSED};
      val = '{dims, mode_bits, sel_bits, CSR_DATA_W'($urandom)};
      n   = poke_unused ? 4 : 3;
      for (int k = 0; k < n; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         do @(posedge clock); while (!csr_ready);
         case (idx[k])
            CSR_DIMS_IN_USE:     dims_reg = val[k];
            CSR_SINGLE_DIM_MODE: mode_reg = val[k][0];
            CSR_SELECTED_DIM:    sel_reg  = val[k][2:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Random point sets: mostly grown to a target size, a few past capacity,
   // with an occasional stray restart. Drains fully at the end.
   task automatic run_phase(input int items, input bit send_idle, input bit recv_idle);
      logic signed [COORD_W-1:0] c [NUM_COORDS];
      logic                      restart_flag;
      req_payload_type           p;
      req_idle_on = send_idle;
      rsp_idle_on = recv_idle;
      for (int k = 0; k < items; k++) begin
         restart_flag = 1'b0;
         if (set_len >= set_target || $urandom_range(24) == 0) begin
            restart_flag = 1'b1;
            set_len      = 0;
            set_target   = ($urandom_range(7) == 0) ? $urandom_range(20, 17)
                                                    : $urandom_range(16, 1);
         end
         set_len++;
         for (int d = 0; d < NUM_COORDS; d++) begin
            case ($urandom_range(9))
               0:       c[d] = C_MIN;
               1:       c[d] = C_MAX;
               2:       c[d] = '0;
               3:       c[d] = -16'sd1;
               4, 5:    c[d] = COORD_W'($urandom_range(200)) - 16'sd100;
               default: c[d] = COORD_W'($urandom);
            endcase
         end
         p = '{restart_flag, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
         offer_point(p, 1'b0, NOT_TYPED);
      end
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // Result side pacing: random gaps, plus one long hold on request.
   initial begin : rsp_pacing
      int unsigned hold_left;
      int unsigned gap_left;
      hold_left = 0;
      gap_left  = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            hold_left  = LONG_HOLD;
         end
         if (hold_left == 0 && gap_left == 0 && rsp_idle_on && $urandom_range(3) == 0)
            gap_left = pick_gap();
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (gap_left != 0) begin
            gap_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each result transfer against the oldest entry due.
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (matrix_entries_due.size() == 0) begin
            note_failure($sformatf("entry %0d arrived with none due: row %0d col %0d dist %0d",
                                   results_checked, rsp_payload.row_index,
                                   rsp_payload.col_index, rsp_payload.distance));
         end else begin
            want = matrix_entries_due.pop_front();
            if (rsp_payload.row_index !== want.row_index ||
                rsp_payload.col_index !== want.col_index ||
                rsp_payload.distance  !== want.distance  ||
                rsp_payload.last      !== want.last      ||
                rsp_payload.status    !== want.status)
               note_failure($sformatf(
                  "entry %0d: got r%0d c%0d d%0d l%0b s%0b, want r%0d c%0d d%0d l%0b s%0b",
                  results_checked, rsp_payload.row_index, rsp_payload.col_index,
                  rsp_payload.distance, rsp_payload.last, rsp_payload.status,
                  want.row_index, want.col_index, want.distance, want.last,
                  want.status));
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      rows_held   = 0;
      dims_reg    = 4'd8;
      mode_reg    = 1'b0;
      sel_reg     = 3'd0;
      set_len     = 0;
      set_target  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed points under the reset settings
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      for (int k = 0; k < DIRECTED_ROWS; k++)
         offer_point(DIRECTED_TABLE[k].point, DIRECTED_TABLE[k].check_typed,
                     DIRECTED_TABLE[k].typed_result);
      req_valid <= 1'b0;
      wait_drained();

      // zero dimensions counts as one
      configure(4'd0, 4'd0, 4'd0, 1'b0);
      run_phase(35, 1'b1, 1'b1);
      // dimensions above eight clamp; selection ignored, no idling
      configure(4'd15, 4'd0, 4'd5, 1'b0);
      run_phase(35, 1'b0, 1'b0);
      // single dimension, top coordinate; upper data bits set, unused index
      configure(4'd1, 4'b1011, 4'b1111, 1'b1);
      run_phase(35, 1'b1, 1'b1);
      // single dimension 0 while the result side holds off: input backs up
      configure(4'd6, 4'd1, 4'd0, 1'b0);
      hold_asked = 1'b1;
      run_phase(35, 1'b0, 1'b0);
      configure(4'd5, 4'd0, 4'd11, 1'b1);
      run_phase(35, 1'b1, 1'b0);
      configure(4'd8, 4'd0, 4'd0, 1'b0);
      run_phase(35, 1'b0, 1'b1);
      configure(4'd3, 4'd0, 4'd2, 1'b0);
      run_phase(35, 1'b1, 1'b1);
      configure(4'd8, 4'd1, 4'd4, 1'b0);
      run_phase(35, 1'b1, 1'b1);

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d points (%0d refused on a full store) under %0d register settings;",
               points_sent, points_dropped, settings_used + 1);
      $display("%0d matrix entries compared, %0d failures.", results_checked, fail_count);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // hard stop in case the handshake hangs
   initial begin
      #(RUN_LIMIT);
      $display("Run limit hit with %0d entries still due", matrix_entries_due.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/psdm_pkg.sv
rtl/psdm_store.sv
rtl/psdm_lane.sv
rtl/psdm_merge.sv
rtl/pairwise_squared_distance_matrix_unit.sv
test/tb_pairwise_squared_distance_matrix_unit.sv
